>>> rtl/tscs_pkg.sv
// Shared types and codes for the time-slotted circuit switch.
// No dependencies; imported by every module in rtl/.
package tscs_pkg;

  localparam int PORTS_DEF  = 16;
  localparam int SLICES_DEF = 64;

  // Largest slice count the 6-bit slice counter can cycle through
  localparam logic [6:0] SLICE_CAP = 7'd64;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_PACKET = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FWD       = 3'd1,
    ST_GUARD     = 3'd2,
    ST_NO_ENTRY  = 3'd3,
    ST_BAD_PORT  = 3'd4,
    ST_REJECT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_SLICE_DUR  = 2'd0,
    REG_NUM_SLICES = 2'd1,
    REG_GUARD      = 2'd2,
    REG_NUM_PORTS  = 2'd3
  } reg_idx_t;

  // One schedule table word
  typedef struct packed {
    logic       valid;
    logic [7:0] egress;
  } tscs_entry_t;

  // Time base status seen by the decision logic
  typedef struct packed {
    logic [5:0] slice_now;     // current slice
    logic [5:0] slice_ticked;  // current slice once a pending tick is applied
    logic       in_guard;      // offset lies in the dark tail of the slice
  } tscs_time_t;

endpackage

>>> rtl/tscs_sched_mem.sv
// Schedule table: one write port, one read port, registered read data.
// Depends on tscs_pkg for the entry word type.
module tscs_sched_mem
  import tscs_pkg::*;
#(
  parameter int DEPTH = PORTS_DEF * SLICES_DEF,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tscs_entry_t   wdata,
  input  logic [AW-1:0] raddr,
  output tscs_entry_t   rdata
);

  tscs_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tscs_timebase.sv
// Microsecond time base: offset within the slice and cyclic slice counter.
// Depends on tscs_pkg for the status struct and the slice cap.
module tscs_timebase
  import tscs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [31:0] slice_dur,
  input  logic [6:0]  num_slices,
  input  logic [31:0] guard_us,
  output tscs_time_t  tinfo
);

  logic [31:0] offset;
  logic [31:0] offset_next;
  logic [5:0]  slice_cnt;
  logic [5:0]  slice_cnt_next;
  logic [6:0]  n_eff;
  logic        dur_zero;

  // A counter at or beyond the slice count reads as slice 0
  function automatic logic [5:0] pick_slice(input logic [5:0] sc, input logic [6:0] n,
                                            input logic dz);
    if (dz || n == 7'd0 || {1'b0, sc} >= n) begin
      return 6'd0;
    end
    return sc;
  endfunction

  always_comb begin
    n_eff          = (num_slices > SLICE_CAP) ? SLICE_CAP : num_slices;
    dur_zero       = (slice_dur == 32'd0);
    offset_next    = offset;
    slice_cnt_next = slice_cnt;
    if (dur_zero) begin
      offset_next    = 32'd0;
      slice_cnt_next = 6'd0;
    end else if ({1'b0, offset} + 33'd1 >= {1'b0, slice_dur}) begin
      offset_next = 32'd0;
      if (n_eff == 7'd0 || {1'b0, slice_cnt} + 7'd1 >= n_eff) begin
        slice_cnt_next = 6'd0;
      end else begin
        slice_cnt_next = slice_cnt + 6'd1;
      end
    end else begin
      offset_next = offset + 32'd1;
    end

    tinfo.slice_now    = pick_slice(slice_cnt, n_eff, dur_zero);
    tinfo.slice_ticked = pick_slice(slice_cnt_next, n_eff, dur_zero);
    tinfo.in_guard     = (guard_us != 32'd0) && !dur_zero &&
                         ({1'b0, offset} + {1'b0, guard_us} >= {1'b0, slice_dur});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= 32'd0;
      slice_cnt <= 6'd0;
    end else if (tick) begin
      offset    <= offset_next;
      slice_cnt <= slice_cnt_next;
    end
  end

endmodule

>>> rtl/time_slotted_circuit_switch_top.sv
// Top level of the time-slotted circuit switch forwarding decision.
// Depends on tscs_pkg, tscs_timebase and tscs_sched_mem.
//
// Usage:
//   Input beats (s_*) carry a command in s_tuser: tick one microsecond,
//   packet arrival, write a schedule entry, or clear the whole schedule.
//   Every input beat yields exactly one output beat (m_*) with a status in
//   m_tuser and the chosen port, current slice and running totals in m_tdata.
//   Registers are written on the cfg_* channel; the user must write them only
//   while the block is idle (not enforced by the block); cfg_ready is always high.
// Beat flow:
//   Tick, packet and write beats: the schedule table is read in the accept
//   cycle, the word comes back in the finish state and the result is
//   registered there; no new beat is taken until the finish state is over.
//   The table read (one synchronous memory port) is why that state exists.
//   Clear beats sweep the table one entry a cycle, all PORTS*SLICES entries
//   (1024 at the defaults), before the output beat appears.
// Reset:
//   rst is synchronous. After reset the same sweep clears every valid mark
//   with s_tready low throughout; config writes are taken meanwhile.
// Stall:
//   A result waits in the output register while m_tready is low; a new beat
//   is accepted in that time only if the result is taken in the same cycle.
module time_slotted_circuit_switch_top
  import tscs_pkg::*;
#(
  parameter int PORTS  = PORTS_DEF,
  parameter int SLICES = SLICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // ingress[7:0], entry_slice[15:8], egress[23:16]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // fwd_port[7:0], slice_now[13:8], forward_total[45:14],
                                 // drop_total[77:46], entry_total[88:78], zero[95:89]
  output logic [2:0]  m_tuser,   // status[2:0]
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TABLE = PORTS * SLICES;
  localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;
  localparam int EW    = $clog2(TABLE + 1);
  localparam int CW    = (EW > 11) ? EW : 11;
  localparam int IW    = 17;  // wide enough for any ingress * SLICES + slice

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_FIN
  } state_t;

  // Configuration registers
  logic [31:0] slice_dur;
  logic [6:0]  num_slices;
  logic [31:0] guard_us;
  logic [4:0]  num_ports;

  // Sequencer and held beat
  state_t      state;
  logic [AW-1:0] sweep_addr;
  logic        sweep_reply;
  cmd_t        cmd_q;
  logic [7:0]  eg_q;
  logic        ing_bad_q;
  logic        slice_bad_q;
  logic        wr_bad_q;
  logic [AW-1:0] addr_q;

  // Running totals
  logic [31:0]   fwd_cnt;
  logic [31:0]   drop_cnt;
  logic [CW-1:0] entry_cnt;

  // Accept-side decode
  logic          accept;
  cmd_t          cmd_in;
  logic [7:0]    ing_in;
  logic [7:0]    sl_in;
  logic          pkt_ing_bad;
  logic          pkt_slice_bad;
  logic          wr_bad;
  logic [7:0]    rd_slice;
  logic [IW-1:0] idx_wide;
  logic [AW-1:0] raddr;

  // Memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  tscs_entry_t   mem_wdata;
  tscs_entry_t   mem_rdata;

  // Finish-cycle results
  tscs_time_t    tinfo;
  logic          tick;
  status_t       res_status;
  logic [7:0]    res_port;
  logic [5:0]    res_slice;
  logic [31:0]   fwd_next;
  logic [31:0]   drop_next;
  logic [CW-1:0] entry_next;
  logic          sweep_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_dur  <= 32'd0;
      num_slices <= 7'd0;
      guard_us   <= 32'd0;
      num_ports  <= 5'd0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SLICE_DUR:  slice_dur  <= cfg_data;
        REG_NUM_SLICES: num_slices <= cfg_data[6:0];
        REG_GUARD:      guard_us   <= cfg_data;
        REG_NUM_PORTS:  num_ports  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  tscs_timebase u_timebase (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .slice_dur  (slice_dur),
    .num_slices (num_slices),
    .guard_us   (guard_us),
    .tinfo      (tinfo)
  );

  tscs_sched_mem #(
    .DEPTH (TABLE),
    .AW    (AW)
  ) u_sched_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  // Take a beat only when the output register will be free at finish time
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Decode the offered beat and form the table address for the read
  always_comb begin
    cmd_in        = cmd_t'(s_tuser);
    ing_in        = s_tdata[7:0];
    sl_in         = s_tdata[15:8];
    pkt_ing_bad   = (ing_in >= {3'b000, num_ports}) || ({1'b0, ing_in} >= 9'(PORTS));
    pkt_slice_bad = ({3'b000, tinfo.slice_now} >= 9'(SLICES));
    wr_bad        = ({1'b0, ing_in} >= 9'(PORTS)) || ({1'b0, sl_in} >= 9'(SLICES));
    rd_slice      = (cmd_in == CMD_WRITE) ? sl_in : {2'b00, tinfo.slice_now};
    idx_wide      = IW'(ing_in) * IW'(SLICES) + IW'(rd_slice);
    // Park the address at zero when it would fall outside the table, or when a packet's ingress is beyond num_ports
    if ((cmd_in == CMD_WRITE) ? wr_bad : (pkt_ing_bad || pkt_slice_bad)) begin
      raddr = '0;
    end else begin
      raddr = idx_wide[AW-1:0];
    end
  end

  // Sweep owns the write port; otherwise a valid write lands in the finish cycle
  always_comb begin
    sweep_last = (sweep_addr == AW'(TABLE - 1));
    if (state == S_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '{valid: 1'b0, egress: 8'd0};
    end else begin
      mem_we    = (state == S_FIN) && (cmd_q == CMD_WRITE) && !wr_bad_q;
      mem_waddr = addr_q;
      mem_wdata = '{valid: 1'b1, egress: eg_q};
    end
  end

  assign tick = (state == S_FIN) && (cmd_q == CMD_TICK);

  // Finish one beat with the table word that came back
  always_comb begin
    res_status = ST_DONE;
    res_port   = 8'd0;
    res_slice  = tinfo.slice_now;
    fwd_next   = fwd_cnt;
    drop_next  = drop_cnt;
    entry_next = entry_cnt;
    case (cmd_q)
      CMD_TICK: begin
        res_slice = tinfo.slice_ticked;
      end
      CMD_PACKET: begin
        if (ing_bad_q) begin
          res_status = ST_BAD_PORT;
        end else if (tinfo.in_guard) begin
          res_status = ST_GUARD;
        end else if (slice_bad_q || !mem_rdata.valid) begin
          res_status = ST_NO_ENTRY;
        end else if (mem_rdata.egress >= {3'b000, num_ports}) begin
          res_status = ST_BAD_PORT;
        end else begin
          res_status = ST_FWD;
          res_port   = mem_rdata.egress;
        end
        if (res_status == ST_FWD) begin
          fwd_next = (fwd_cnt == 32'hFFFF_FFFF) ? fwd_cnt : fwd_cnt + 32'd1;
        end else begin
          drop_next = (drop_cnt == 32'hFFFF_FFFF) ? drop_cnt : drop_cnt + 32'd1;
        end
      end
      CMD_WRITE: begin
        if (wr_bad_q) begin
          res_status = ST_REJECT;
        end else if (!mem_rdata.valid) begin
          entry_next = entry_cnt + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      fwd_cnt     <= 32'd0;
      drop_cnt    <= 32'd0;
      entry_cnt   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_last) begin
            state      <= S_IDLE;
            sweep_addr <= '0;
            if (sweep_reply) begin
              m_tvalid <= 1'b1;
              m_tuser  <= ST_DONE;
              m_tdata  <= {7'd0, entry_cnt[10:0], drop_cnt, fwd_cnt,
                           tinfo.slice_now, 8'd0};
            end
          end else begin
            sweep_addr <= sweep_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (cmd_in == CMD_CLEAR) begin
              // Drop every valid mark; the reply follows the sweep
              state       <= S_SWEEP;
              sweep_addr  <= '0;
              sweep_reply <= 1'b1;
              entry_cnt   <= '0;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          state     <= S_IDLE;
          fwd_cnt   <= fwd_next;
          drop_cnt  <= drop_next;
          entry_cnt <= entry_next;
          m_tvalid  <= 1'b1;
          m_tuser   <= res_status;
          m_tdata   <= {7'd0, entry_next[10:0], drop_next, fwd_next, res_slice, res_port};
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the accepted beat for the finish cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q       <= cmd_in;
      eg_q        <= s_tdata[23:16];
      ing_bad_q   <= pkt_ing_bad;
      slice_bad_q <= pkt_slice_bad;
      wr_bad_q    <= wr_bad;
      addr_q      <= raddr;
    end
  end

  // A non-clear beat always yields a valid result, registered from the finish state after accept
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd_in != CMD_CLEAR) |-> ##2 m_tvalid)
    else $error("result missing two cycles after accept");

  // The valid-entry count can never exceed the table
  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_cnt <= CW'(TABLE))
    else $error("entry count beyond table size");

  // Packet totals only grow
  a_fwd_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fwd_cnt >= $past(fwd_cnt) && drop_cnt >= $past(drop_cnt)))
    else $error("packet total decreased");

  // No beat is taken while the sweep owns the table
  a_sweep_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> !s_tready)
    else $error("beat accepted during table sweep");

endmodule
